### rtl/ising_lattice_metropolis_flip_top_defines.svh
// Assertion macros for the Ising lattice flip engine.
// Used by rtl/ising_lattice_metropolis_flip_top.sv; expects clock and reset in scope.
`ifndef ISING_LATTICE_METROPOLIS_FLIP_TOP_DEFINES_SVH
`define ISING_LATTICE_METROPOLIS_FLIP_TOP_DEFINES_SVH

// Antecedent holds -> consequent holds in the same cycle
`define ILMF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds -> consequent holds in the next cycle
`define ILMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ilmf_pkg.sv
// Shared types and constants for the Ising lattice Metropolis flip engine.
// No dependencies; used by rtl/ising_lattice_metropolis_flip_top.sv.
package ilmf_pkg;

   // Lattice geometry: side is a power of two, so row and column are bit fields
   localparam int SIDE     = 32;
   localparam int ROW_W    = $clog2(SIDE);
   localparam int ADDR_W   = 2 * ROW_W;
   localparam int SITES    = SIDE * SIDE;

   // Field widths
   localparam int SITE_W   = 10;
   localparam int DRAW_W   = 16;
   localparam int ENERGY_W = 13;
   localparam int DE_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Energy of the all-up lattice
   localparam logic signed [ENERGY_W-1:0] RESET_ENERGY = ENERGY_W'(-2 * SITES);

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FLIP  = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEPT_DE4 = 2'd0,
      CSR_ACCEPT_DE8 = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RD0,
      S_RD1,
      S_RD2,
      S_EXEC
   } state_type;

endpackage

### rtl/ising_lattice_metropolis_flip_top.sv
// Ising lattice Metropolis flip engine: spin memory, energy register, control.
// Depends on rtl/ilmf_pkg.sv and rtl/ising_lattice_metropolis_flip_top_defines.svh.
// Result: the result strobe rises once the accepted word has passed through the states
//   S_RD0, S_RD1, S_RD2 and S_EXEC; rsp_valid is registered from S_EXEC.
// Flow: one word at a time; no new word is taken until the block is back in idle,
//   after five spin reads over a two-port memory (S_RD0 to S_RD2) and one execute state.
// Reset: synchronous; a clearing pass writes all 1024 spins to +1 (busy high),
//   energy returns to -2048 and both thresholds to 0.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
`include "ising_lattice_metropolis_flip_top_defines.svh"

module ising_lattice_metropolis_flip_top (
   input  logic                                    clock,
   input  logic                                    reset,
   // request
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_opcode,
   input  logic [ilmf_pkg::SITE_W-1:0]             req_site,
   input  logic                                    req_spin_value,
   input  logic [ilmf_pkg::DRAW_W-1:0]             req_random_draw,
   // response
   output logic                                    rsp_valid,
   output logic                                    rsp_accepted,
   output logic                                    rsp_spin_now,
   output logic signed [ilmf_pkg::ENERGY_W-1:0]    rsp_energy_total,
   output logic signed [ilmf_pkg::DE_W-1:0]        rsp_energy_change,
   // configuration
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ilmf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ilmf_pkg::CSR_DAT_W-1:0]          csr_wdata
);

   localparam int ROW_W  = ilmf_pkg::ROW_W;
   localparam int ADDR_W = ilmf_pkg::ADDR_W;

   // State machine
   ilmf_pkg::state_type state_ff, state_in;

   // Clearing counter
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_done;

   // Latched request word
   logic [1:0]                    op_ff;
   logic [ilmf_pkg::SITE_W-1:0]   site_ff;
   logic                          wbit_ff;
   logic [ilmf_pkg::DRAW_W-1:0]   draw_ff;

   // Thresholds
   logic [ilmf_pkg::CSR_DAT_W-1:0] level_de4_ff, level_de8_ff;

   // Energy
   logic signed [ilmf_pkg::ENERGY_W-1:0] energy_ff, energy_in;

   // Spin memory and its ports
   logic                spin_mem [ilmf_pkg::SITES];
   logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b, wr_addr;
   logic                rd_a_ff, rd_b_ff;
   logic                mem_we, mem_wdata;

   // Captured spins
   logic center_ff, up_ff, dn_ff, lf_ff;
   logic rt_spin;

   // Neighbour addresses
   logic [ROW_W-1:0]  row, col, row_up, row_dn, col_lf, col_rt;
   logic [ADDR_W-1:0] addr_c, addr_up, addr_dn, addr_lf, addr_rt;

   // Execute datapath
   logic                              in_range;
   logic [2:0]                        n_minus;
   logic signed [ilmf_pkg::DE_W-1:0]  quad, de, change;
   logic                              take, new_spin, spin_out, acc;

   // Response registers
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_accepted_ff, rsp_spin_now_ff;
   logic signed [ilmf_pkg::ENERGY_W-1:0] rsp_energy_total_ff;
   logic signed [ilmf_pkg::DE_W-1:0]  rsp_energy_change_ff;

   logic exec;
   logic accept;

   // ------------------------------------------------------------------
   // Control outputs
   always_comb begin
      busy         = (state_ff != ilmf_pkg::S_IDLE);
      exec         = (state_ff == ilmf_pkg::S_EXEC);
      rsp_valid_in = exec;
   end

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign clr_done  = (clr_cnt_ff == ADDR_W'(ilmf_pkg::SITES - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ilmf_pkg::S_CLEAR: if (clr_done) state_in = ilmf_pkg::S_IDLE;
         ilmf_pkg::S_IDLE:  if (start) state_in = ilmf_pkg::S_RD0;
         ilmf_pkg::S_RD0:   state_in = ilmf_pkg::S_RD1;
         ilmf_pkg::S_RD1:   state_in = ilmf_pkg::S_RD2;
         ilmf_pkg::S_RD2:   state_in = ilmf_pkg::S_EXEC;
         ilmf_pkg::S_EXEC:  state_in = ilmf_pkg::S_IDLE;
         default:           state_in = ilmf_pkg::S_IDLE;
      endcase
   end

   assign clr_cnt_in = clr_cnt_ff + ADDR_W'(1);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilmf_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         level_de4_ff <= '0;
         level_de8_ff <= '0;
         energy_ff    <= ilmf_pkg::RESET_ENERGY;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ilmf_pkg::S_CLEAR) begin
            clr_cnt_ff <= clr_cnt_in;
         end
         if (exec) begin
            energy_ff <= energy_in;
         end
         // register writes; indexes beyond the list are dropped
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ilmf_pkg::CSR_ACCEPT_DE4: level_de4_ff <= csr_wdata;
               ilmf_pkg::CSR_ACCEPT_DE8: level_de8_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Request word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         site_ff <= req_site;
         wbit_ff <= req_spin_value;
         draw_ff <= req_random_draw;
      end
   end

   // ------------------------------------------------------------------
   // Torus neighbours: row and column wrap naturally in ROW_W bits
   always_comb begin
      row     = site_ff[ADDR_W-1:ROW_W];
      col     = site_ff[ROW_W-1:0];
      row_up  = row - ROW_W'(1);
      row_dn  = row + ROW_W'(1);
      col_lf  = col - ROW_W'(1);
      col_rt  = col + ROW_W'(1);
      addr_c  = {row, col};
      addr_up = {row_up, col};
      addr_dn = {row_dn, col};
      addr_lf = {row, col_lf};
      addr_rt = {row, col_rt};
   end

   // Read address selection per read cycle
   always_comb begin
      unique case (state_ff)
         ilmf_pkg::S_RD0: begin
            rd_addr_a = addr_c;
            rd_addr_b = addr_up;
         end
         ilmf_pkg::S_RD1: begin
            rd_addr_a = addr_dn;
            rd_addr_b = addr_lf;
         end
         default: begin
            rd_addr_a = addr_rt;
            rd_addr_b = addr_rt;
         end
      endcase
   end

   // Write port: clearing pass or execute write-back. Items run one at a
   // time, so a write-back never overlaps the reads of the same word.
   always_comb begin
      if (state_ff == ilmf_pkg::S_CLEAR) begin
         mem_we    = 1'b1;
         wr_addr   = clr_cnt_ff;
         mem_wdata = 1'b0;
      end else begin
         mem_we    = exec && in_range && (new_spin != center_ff);
         wr_addr   = addr_c;
         mem_wdata = new_spin;
      end
   end

   // Spin memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         spin_mem[wr_addr] <= mem_wdata;
      end
      rd_a_ff <= spin_mem[rd_addr_a];
      rd_b_ff <= spin_mem[rd_addr_b];
   end

   // Capture read data as it returns
   always_ff @(posedge clock) begin
      if (state_ff == ilmf_pkg::S_RD1) begin
         center_ff <= rd_a_ff;
         up_ff     <= rd_b_ff;
      end
      if (state_ff == ilmf_pkg::S_RD2) begin
         dn_ff <= rd_a_ff;
         lf_ff <= rd_b_ff;
      end
   end

   assign rt_spin = rd_a_ff;

   // ------------------------------------------------------------------
   // dE = 2*s*(sum of neighbours); neighbour sum = 4 - 2*(number of down spins)
   always_comb begin
      in_range = (32'(site_ff) < 32'(ilmf_pkg::SITES));
      n_minus  = 3'(up_ff) + 3'(dn_ff) + 3'(lf_ff) + 3'(rt_spin);
      quad     = {n_minus, 2'b00};
      de       = center_ff ? (quad - 5'sd8) : (5'sd8 - quad);
      take     = de[ilmf_pkg::DE_W-1] || (de == 5'sd0)
              || ((de == 5'sd4) && (draw_ff < level_de4_ff))
              || ((de == 5'sd8) && (draw_ff < level_de8_ff));

      new_spin = center_ff;
      change   = '0;
      acc      = 1'b0;
      unique case (op_ff)
         ilmf_pkg::OP_WRITE: begin
            new_spin = wbit_ff;
            if (wbit_ff != center_ff) change = de;
         end
         ilmf_pkg::OP_FLIP: begin
            if (take) begin
               new_spin = ~center_ff;
               change   = de;
               acc      = 1'b1;
            end
         end
         default: ;   // read, and the unused code, change nothing
      endcase

      // out-of-range site: ignored
      if (!in_range) begin
         change   = '0;
         acc      = 1'b0;
         spin_out = 1'b0;
      end else begin
         spin_out = new_spin;
      end

      energy_in = energy_ff + ilmf_pkg::ENERGY_W'(change);
   end

   // Response word
   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_accepted_ff      <= acc;
         rsp_spin_now_ff      <= spin_out;
         rsp_energy_total_ff  <= energy_in;
         rsp_energy_change_ff <= change;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_spin_now      = rsp_spin_now_ff;
   assign rsp_energy_total  = rsp_energy_total_ff;
   assign rsp_energy_change = rsp_energy_change_ff;

   // ------------------------------------------------------------------
   // Assertions
   `ILMF_ASSERT_SAME(a_rsp_in_idle, rsp_valid_ff, state_ff == ilmf_pkg::S_IDLE, "strobe outside idle")
   `ILMF_ASSERT_NEXT(a_accept_reads, accept, state_ff == ilmf_pkg::S_RD0, "accepted word not read")
   `ILMF_ASSERT_NEXT(a_exec_strobe, exec, rsp_valid_ff, "execute without result strobe")
   `ILMF_ASSERT_SAME(a_energy_hold, rsp_valid_ff && (rsp_energy_change_ff == 5'sd0), $stable(energy_ff), "energy moved without change")

endmodule
